[rtl/palette_dedup_slot_allocator_defines.svh]
// Assertion macros for the palette slot allocator.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef PALETTE_DEDUP_SLOT_ALLOCATOR_DEFINES_SVH
`define PALETTE_DEDUP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PDSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdsa: same-cycle check failed");
// next-cycle implication
`define PDSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdsa: next-cycle check failed");
`else
`define PDSA_ASSERT_IMP(lbl, ante, cons)
`define PDSA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/pdsa_pkg.sv]
package pdsa_pkg;

    // field and state widths
    localparam int COLOUR_W  = 16;
    localparam int POS_W     = 5;
    localparam int LEN_W     = 5;
    localparam int SLOT_W    = 3;
    localparam int NF_W      = 4;
    localparam int CNT_W     = 8;
    localparam int PNUM_W    = 7;
    localparam int TIX_W     = 8;
    localparam int META_W    = LEN_W + PNUM_W;

    // default configuration
    localparam int DEF_SLOTS   = 8;
    localparam int DEF_COLOURS = 16;
    localparam int DEF_LIMIT   = 128;

    // table index offset of the sprite region
    localparam int SPRITE_BASE = 128;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_LIMIT    = 2'd3
    } status_t;

    // first stored owner that matches the finished palette
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [PNUM_W-1:0] owner;
    } match_t;

endpackage

[rtl/pdsa_lane_ram.sv]
module pdsa_lane_ram #(
    parameter int LANES  = 1,
    parameter int LANE_W = 1,
    parameter int ADDR_W = 1
) (
    input  logic                    clk,
    input  logic                    re,
    input  logic [ADDR_W-1:0]       raddr,
    output logic [LANES*LANE_W-1:0] rdata,
    input  logic [LANES-1:0]        we,
    input  logic [ADDR_W-1:0]       waddr,
    input  logic [LANE_W-1:0]       wdata
);

    logic [LANES*LANE_W-1:0] mem [2**ADDR_W];
    logic [LANES*LANE_W-1:0] rdata_reg;

    // registered read, per-lane write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        for (int l = 0; l < LANES; l++)
        begin
            if (we[l])
            begin
                mem[waddr][l*LANE_W +: LANE_W] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pdsa_match.sv]
module pdsa_match #(
    parameter int SLOTS = pdsa_pkg::DEF_SLOTS
) (
    input  logic [SLOTS*pdsa_pkg::COLOUR_W-1:0] row_colours,
    input  logic [pdsa_pkg::COLOUR_W-1:0]       colour,
    input  logic [SLOTS-1:0]                    mask_in,
    input  logic [SLOTS*pdsa_pkg::META_W-1:0]   row_meta,
    input  logic [pdsa_pkg::LEN_W-1:0]          len,
    output logic [SLOTS-1:0]                    mask_out,
    output pdsa_pkg::match_t                    result
);

    import pdsa_pkg::*;

    // drop every owner whose word at this position differs
    always_comb
    begin
        mask_out = mask_in;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (row_colours[s*COLOUR_W +: COLOUR_W] != colour)
            begin
                mask_out[s] = 1'b0;
            end
        end
    end

    // lowest surviving owner with the same length
    always_comb
    begin
        result = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (mask_out[s] && (row_meta[s*META_W + PNUM_W +: LEN_W] == len))
            begin
                result.hit   = 1'b1;
                result.slot  = SLOT_W'(s);
                result.owner = row_meta[s*META_W +: PNUM_W];
            end
        end
    end

endmodule

[rtl/palette_dedup_slot_allocator.sv]
// The last colour word is registered in the compare stage, its result in the result
// register; both can stall on out_ready. Throughput: one colour word per cycle
// inside a palette; after the last word, input is held off for the owner table update.
// Reset: control (positions, free-slot counts, palette count, valids) clears
// at once; colour and owner memories are not cleared, only slots below the
// free-slot count of a region are ever read.
`include "palette_dedup_slot_allocator_defines.svh"

module palette_dedup_slot_allocator #(
    parameter int SLOTS_PER_REGION = pdsa_pkg::DEF_SLOTS,
    parameter int COLOURS_PER_SLOT = pdsa_pkg::DEF_COLOURS,
    parameter int PALETTE_LIMIT    = pdsa_pkg::DEF_LIMIT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          region,
    input  logic [pdsa_pkg::COLOUR_W-1:0] colour,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [pdsa_pkg::SLOT_W-1:0]   slot,
    output logic [pdsa_pkg::TIX_W-1:0]    table_index,
    output logic                          shared,
    output logic [pdsa_pkg::PNUM_W-1:0]   palette_number,
    output logic [pdsa_pkg::PNUM_W-1:0]   owner_number,
    output logic [pdsa_pkg::LEN_W-1:0]    colour_count
);

    import pdsa_pkg::*;

    localparam int PW    = $clog2(COLOURS_PER_SLOT);
    localparam int ROW_W = PW + 1;

    // front-end state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             cur_region_reg, cur_region_next;
    logic [NF_W-1:0]  nf_reg [2];
    logic [CNT_W-1:0] cnt_reg;
    logic [SLOTS_PER_REGION-1:0] mask_reg;

    // compare stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_last_reg;
    logic                s1_first_reg;
    logic                s1_inrange_reg;
    logic                s1_region_reg;
    logic [COLOUR_W-1:0] s1_colour_reg;
    logic [POS_W-1:0]    s1_len_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TIX_W-1:0]    out_tix_reg;
    logic                out_shared_reg;
    logic [PNUM_W-1:0]   out_pnum_reg;
    logic [PNUM_W-1:0]   out_onum_reg;
    logic [LEN_W-1:0]    out_count_reg;

    logic                in_accept;
    logic                region_sel;
    logic                pos_in_range;
    logic [POS_W-1:0]    pos_inc;
    logic [NF_W-1:0]     nf_sel;
    logic [SLOTS_PER_REGION-1:0] colour_we;
    logic [SLOTS_PER_REGION-1:0] meta_we;
    logic [SLOTS_PER_REGION*COLOUR_W-1:0] row_colours;
    logic [SLOTS_PER_REGION*META_W-1:0]   row_meta;

    logic [NF_W-1:0]     nf_s1;
    logic [SLOTS_PER_REGION-1:0] mask_start;
    logic [SLOTS_PER_REGION-1:0] mask_cmp;
    logic [SLOTS_PER_REGION-1:0] mask_eff;
    match_t              match;
    logic                s1_go;
    logic                fin;
    logic                limit_hit;
    logic                too_many;
    logic                has_free;
    logic                fin_new;
    logic                fin_count;

    status_t             res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [TIX_W-1:0]    res_tix;
    logic                res_shared;
    logic [PNUM_W-1:0]   res_pnum;
    logic [PNUM_W-1:0]   res_onum;
    logic [LEN_W-1:0]    res_count;

    // input side: hold off while a finished palette waits for allocation
    assign in_ready     = !(s1_valid_reg && s1_last_reg);
    assign in_accept    = in_valid && in_ready;
    assign region_sel   = (pos_reg == '0) ? region : cur_region_reg;
    assign pos_in_range = (pos_reg < POS_W'(COLOURS_PER_SLOT));
    assign pos_inc      = (pos_reg <= POS_W'(COLOURS_PER_SLOT)) ? pos_reg + 1'b1 : pos_reg;
    assign nf_sel       = nf_reg[region_sel];

    always_comb
    begin
        pos_next        = pos_reg;
        cur_region_next = cur_region_reg;
        if (in_accept)
        begin
            pos_next        = last ? '0 : pos_inc;
            cur_region_next = region_sel;
        end
    end

    // speculative write of the word into the region's free slot
    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_REGION; s++)
        begin
            colour_we[s] = in_accept && pos_in_range && (nf_sel == NF_W'(s));
        end
    end

    pdsa_lane_ram #(
        .LANES  (SLOTS_PER_REGION),
        .LANE_W (COLOUR_W),
        .ADDR_W (ROW_W)
    ) u_colour_ram (
        .clk   (clk),
        .re    (in_accept && pos_in_range),
        .raddr ({region_sel, pos_reg[PW-1:0]}),
        .rdata (row_colours),
        .we    (colour_we),
        .waddr ({region_sel, pos_reg[PW-1:0]}),
        .wdata (colour)
    );

    // owner length and number, one row per region
    pdsa_lane_ram #(
        .LANES  (SLOTS_PER_REGION),
        .LANE_W (META_W),
        .ADDR_W (1)
    ) u_meta_ram (
        .clk   (clk),
        .re    (in_accept),
        .raddr (region_sel),
        .rdata (row_meta),
        .we    (meta_we),
        .waddr (s1_region_reg),
        .wdata ({s1_len_reg, cnt_reg[PNUM_W-1:0]})
    );

    // compare stage
    assign nf_s1 = nf_reg[s1_region_reg];

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_REGION; s++)
        begin
            mask_start[s] = s1_first_reg ? (NF_W'(s) < nf_s1) : mask_reg[s];
        end
    end

    pdsa_match #(
        .SLOTS (SLOTS_PER_REGION)
    ) u_match (
        .row_colours (row_colours),
        .colour      (s1_colour_reg),
        .mask_in     (mask_start),
        .row_meta    (row_meta),
        .len         (s1_len_reg),
        .mask_out    (mask_cmp),
        .result      (match)
    );

    assign mask_eff  = s1_inrange_reg ? mask_cmp : '0;
    assign s1_go     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign fin       = s1_go && s1_last_reg;
    assign limit_hit = (cnt_reg >= CNT_W'(PALETTE_LIMIT));
    assign too_many  = (s1_len_reg > POS_W'(COLOURS_PER_SLOT));
    assign has_free  = (nf_s1 < NF_W'(SLOTS_PER_REGION));
    assign fin_count = fin && !limit_hit && !too_many;
    assign fin_new   = fin_count && !(s1_inrange_reg && match.hit) && has_free;

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_REGION; s++)
        begin
            meta_we[s] = fin_new && (nf_s1 == NF_W'(s));
        end
    end

    // result of a finished palette
    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_shared = 1'b0;
        res_pnum   = '0;
        res_onum   = '0;
        if (limit_hit)
        begin
            res_status = ST_LIMIT;
        end
        else if (too_many)
        begin
            res_status = ST_TOO_MANY;
        end
        else
        begin
            res_pnum = cnt_reg[PNUM_W-1:0];
            if (s1_inrange_reg && match.hit)
            begin
                res_slot   = match.slot;
                res_shared = 1'b1;
                res_onum   = match.owner;
            end
            else if (has_free)
            begin
                res_slot = nf_s1[SLOT_W-1:0];
                res_onum = cnt_reg[PNUM_W-1:0];
            end
            else
            begin
                res_status = ST_FULL;
                res_onum   = cnt_reg[PNUM_W-1:0];
            end
        end
        res_count = too_many ? LEN_W'(COLOURS_PER_SLOT) : s1_len_reg;
        res_tix   = '0;
        if (res_status == ST_OK)
        begin
            res_tix = (s1_region_reg ? TIX_W'(SPRITE_BASE) : '0)
                    + TIX_W'(res_slot) * TIX_W'(COLOURS_PER_SLOT);
        end
    end

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_go);
    assign out_valid_next = fin || (out_valid_reg && !out_ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            cur_region_reg <= 1'b0;
            nf_reg[0]      <= '0;
            nf_reg[1]      <= '0;
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            cur_region_reg <= cur_region_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            if (fin_new)
            begin
                nf_reg[s1_region_reg] <= nf_s1 + 1'b1;
            end
            if (fin_count)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_last_reg    <= last;
            s1_first_reg   <= (pos_reg == '0);
            s1_inrange_reg <= pos_in_range;
            s1_region_reg  <= region_sel;
            s1_colour_reg  <= colour;
            s1_len_reg     <= pos_inc;
        end
        if (s1_go)
        begin
            mask_reg <= mask_eff;
        end
        if (fin)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_tix_reg    <= res_tix;
            out_shared_reg <= res_shared;
            out_pnum_reg   <= res_pnum;
            out_onum_reg   <= res_onum;
            out_count_reg  <= res_count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign slot           = out_slot_reg;
    assign table_index    = out_tix_reg;
    assign shared         = out_shared_reg;
    assign palette_number = out_pnum_reg;
    assign owner_number   = out_onum_reg;
    assign colour_count   = out_count_reg;

    // checks
    `PDSA_ASSERT_IMP(a_nf_bound, 1'b1, (nf_reg[0] <= NF_W'(SLOTS_PER_REGION)) && (nf_reg[1] <= NF_W'(SLOTS_PER_REGION)))
    `PDSA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(PALETTE_LIMIT))
    `PDSA_ASSERT_IMP(a_pos_bound, 1'b1, pos_reg <= POS_W'(COLOURS_PER_SLOT + 1))
    `PDSA_ASSERT_NXT(a_fin_out, fin, out_valid_reg)
    `PDSA_ASSERT_IMP(a_fail_zero, out_valid_reg && (out_status_reg != ST_OK), (out_slot_reg == '0) && (out_tix_reg == '0) && !out_shared_reg)

endmodule
